// File: src/grc_pkg.sv
// Shared types and constants for the graph reachability check.
// Used by grc_row_mem, grc_closure and graph_reachability_check.
package grc_pkg;

    // Width of one stored adjacency row and of the node-count register.
    localparam int ROW_W    = 32;
    localparam int NC_W     = 6;
    localparam int IDX_W    = 5;
    localparam logic [NC_W-1:0] NC_RESET = NC_W'(32);

    // Verdict codes.
    typedef enum logic [1:0] {
        V_PASS    = 2'd0,
        V_UNREACH = 2'd1,
        V_NO_END  = 2'd2
    } t_verdict;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FWD  = 2'd1,
        S_BWD  = 2'd2
    } t_state;

    // Result strobe and verdict handed from the sequencer to the top level.
    typedef struct packed {
        logic     done;
        t_verdict verdict;
    } t_clo_status;

endpackage

// File: src/grc_row_mem.sv
// Adjacency row storage: one write port, one read port with registered data.
// Depends on grc_pkg for the row width.
module grc_row_mem #(
    parameter int MAX_NODES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] i_wr_addr,
    input  logic [grc_pkg::ROW_W-1:0]    i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] i_rd_addr,
    output logic [grc_pkg::ROW_W-1:0]    o_rd_data
);

    logic [grc_pkg::ROW_W-1:0] r_mem [MAX_NODES];
    logic [grc_pkg::ROW_W-1:0] r_rd_data;

    // Store incoming rows.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register the read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/grc_closure.sv
// Closure sequencer: sweeps the stored rows through one shared
// mask-combine unit until the forward, then the backward, set settles.
// Depends on grc_pkg for the state, verdict and status types.
module grc_closure #(
    parameter int MAX_NODES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_go,
    input  logic [$clog2(MAX_NODES+1)-1:0]   i_n_eff,
    input  logic [MAX_NODES-1:0]             i_mask,
    input  logic [MAX_NODES-1:0]             i_row,
    output logic                             o_rd_en,
    output logic [$clog2(MAX_NODES)-1:0]     o_rd_addr,
    output logic                             o_busy,
    output grc_pkg::t_clo_status             o_status
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);

    grc_pkg::t_state      r_state, n_state;
    logic [NW-1:0]        r_idx, n_idx;
    logic [MAX_NODES-1:0] r_reach, n_reach;
    logic                 r_chg, n_chg;
    logic                 r_fwd_ok, n_fwd_ok;
    grc_pkg::t_clo_status r_status, n_status;

    logic [AW-1:0]        proc_idx;
    logic                 proc_en;
    logic                 pass_end;
    logic [MAX_NODES-1:0] masked_row;
    logic [MAX_NODES-1:0] upd_reach;
    logic                 chg_now;

    // Row whose data is on the read port is the one issued last cycle.
    assign proc_idx   = AW'(r_idx - NW'(1));
    assign proc_en    = (r_idx != '0);
    assign pass_end   = (r_idx == i_n_eff);
    assign masked_row = i_row & i_mask;

    // Shared combine unit: forward merges successors, backward marks a predecessor.
    always_comb begin
        upd_reach = r_reach;
        if (proc_en) begin
            if (r_state == grc_pkg::S_FWD) begin
                if (r_reach[proc_idx]) begin
                    upd_reach = r_reach | masked_row;
                end
            end else begin
                if ((masked_row & r_reach) != '0) begin
                    upd_reach = r_reach | (MAX_NODES'(1) << proc_idx);
                end
            end
        end
    end

    assign chg_now = r_chg | (upd_reach != r_reach);

    // Next state and outputs.
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_reach        = r_reach;
        n_chg          = r_chg;
        n_fwd_ok       = r_fwd_ok;
        n_status       = r_status;
        n_status.done  = 1'b0;
        o_rd_en        = 1'b0;
        o_rd_addr      = AW'(r_idx);
        case (r_state)
            grc_pkg::S_IDLE: begin
                if (i_go) begin
                    n_state = grc_pkg::S_FWD;
                    n_idx   = '0;
                    n_reach = MAX_NODES'(1);
                    n_chg   = 1'b0;
                end
            end
            grc_pkg::S_FWD, grc_pkg::S_BWD: begin
                o_rd_en = !pass_end;
                n_reach = upd_reach;
                if (!pass_end) begin
                    n_idx = r_idx + NW'(1);
                    n_chg = chg_now;
                end else if (chg_now) begin
                    // Set grew during this pass: sweep again.
                    n_idx = '0;
                    n_chg = 1'b0;
                end else if (r_state == grc_pkg::S_FWD) begin
                    // Forward set settled: start from the end node.
                    n_fwd_ok = (upd_reach == i_mask);
                    n_state  = grc_pkg::S_BWD;
                    n_idx    = '0;
                    n_chg    = 1'b0;
                    n_reach  = MAX_NODES'(1) << (i_n_eff - NW'(1));
                end else begin
                    // Backward set settled: issue the verdict.
                    n_state       = grc_pkg::S_IDLE;
                    n_status.done = 1'b1;
                    if (!r_fwd_ok) begin
                        n_status.verdict = grc_pkg::V_UNREACH;
                    end else if (upd_reach != i_mask) begin
                        n_status.verdict = grc_pkg::V_NO_END;
                    end else begin
                        n_status.verdict = grc_pkg::V_PASS;
                    end
                end
            end
            default: begin
                n_state = grc_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= grc_pkg::S_IDLE;
            r_idx    <= '0;
            r_chg    <= 1'b0;
            r_status <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_chg    <= n_chg;
            r_status <= n_status;
        end
    end

    // Working set and forward result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach  <= '0;
            r_fwd_ok <= 1'b0;
        end else begin
            r_reach  <= n_reach;
            r_fwd_ok <= n_fwd_ok;
        end
    end

    assign o_busy   = (r_state != grc_pkg::S_IDLE);
    assign o_status = r_status;

endmodule

// File: src/graph_reachability_check.sv
// Graph reachability check. A row request without the last flag is stored and the next
// request may follow at once. A last-row request starts the check: each sweep visits the
// n nodes in use through the single row read port, and the forward and backward sets each
// take sweeps until one adds nothing (at most n sweeps each). busy is high for the whole
// check; the verdict strobes for one cycle right after it and cannot be held off.
// Synchronous active-low reset clears control, node_count goes to 32.
module graph_reachability_check #(
    parameter int MAX_NODES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [grc_pkg::IDX_W-1:0]    i_row_index,
    input  logic [grc_pkg::ROW_W-1:0]    i_row_bits,
    input  logic                         i_last_row,
    output logic                         o_valid,
    output logic [1:0]                   o_verdict,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [grc_pkg::NC_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);

    logic [grc_pkg::NC_W-1:0] r_node_count;
    logic                     accept;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [grc_pkg::ROW_W-1:0] rd_data;
    logic [MAX_NODES-1:0]     row_ext;
    logic [NW-1:0]            n_eff;
    logic [MAX_NODES-1:0]     node_mask;
    grc_pkg::t_clo_status     status;

    // Node-count register; the user must write it only while idle, the block does not enforce this.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= grc_pkg::NC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node_count <= i_cfg_data;
        end
    end

    // Clamp node count to 1..MAX_NODES.
    always_comb begin
        if (r_node_count == '0) begin
            n_eff = NW'(1);
        end else if (32'(r_node_count) > 32'(MAX_NODES)) begin
            n_eff = NW'(MAX_NODES);
        end else begin
            n_eff = NW'(r_node_count);
        end
    end

    // In-use node mask and row widened or narrowed to the node range.
    for (genvar j = 0; j < MAX_NODES; j++) begin : g_node
        assign node_mask[j] = (32'(j) < 32'(n_eff));
        if (j < grc_pkg::ROW_W) begin : g_bit
            assign row_ext[j] = rd_data[j];
        end else begin : g_pad
            assign row_ext[j] = 1'b0;
        end
    end

    // Store accepted rows; drop rows beyond storage.
    assign accept  = start && !busy;
    assign wr_en   = accept && (32'(i_row_index) < 32'(MAX_NODES));
    assign wr_addr = AW'(i_row_index);

    grc_row_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_row_bits),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    grc_closure #(
        .MAX_NODES (MAX_NODES)
    ) u_closure (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (accept && i_last_row),
        .i_n_eff   (n_eff),
        .i_mask    (node_mask),
        .i_row     (row_ext),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_busy    (busy),
        .o_status  (status)
    );

    assign o_valid   = status.done;
    assign o_verdict = status.verdict;

    // A verdict only follows a running check, and the block is free when it shows.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("verdict without a running check");

    a_idle_on_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy still high with verdict");

    a_busy_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_last_row))
        else $error("check started without a last-row request");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict == grc_pkg::V_PASS || o_verdict == grc_pkg::V_UNREACH ||
                     o_verdict == grc_pkg::V_NO_END))
        else $error("reserved verdict code");

endmodule

// File: dv/tb_graph_reachability_check.sv
// Testbench for graph_reachability_check: drives adjacency-row requests and node-count
// writes, predicts each verdict from its own closure model and checks every strobe.
// Depends on grc_pkg and the graph_reachability_check RTL.
module tb_graph_reachability_check;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES         = 32;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 50;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [grc_pkg::IDX_W-1:0] idx;
        logic [grc_pkg::ROW_W-1:0] bits;
        logic                      last;
    } t_row_req;

    typedef enum int {
        G_CHAIN    = 0,
        G_CUT      = 1,
        G_DEAD_END = 2,
        G_RANDOM   = 3
    } t_graph_kind;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic [grc_pkg::IDX_W-1:0] i_row_index = '0;
    logic [grc_pkg::ROW_W-1:0] i_row_bits  = '0;
    logic                      i_last_row  = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [grc_pkg::NC_W-1:0]  i_cfg_data  = '0;
    logic                      busy;
    logic                      o_valid;
    logic [1:0]                o_verdict;
    logic                      o_cfg_ready;

    graph_reachability_check #(
        .MAX_NODES (NODES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_row_index (i_row_index),
        .i_row_bits  (i_row_bits),
        .i_last_row  (i_last_row),
        .o_valid     (o_valid),
        .o_verdict   (o_verdict),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Requests waiting for the driver, and verdicts waiting for the block
    t_row_req                  pending_rows[$];
    grc_pkg::t_verdict         expected_verdicts[$];

    // Predictor state: stored rows and node-count register as seen at the ports
    logic [grc_pkg::ROW_W-1:0] model_rows [NODES];
    logic [grc_pkg::NC_W-1:0]  model_nc     = grc_pkg::NC_RESET;

    // Generator bookkeeping
    logic [NODES-1:0] rows_loaded  = '0;
    int               gen_nodes    = NODES;
    int               gen_count    = 0;
    logic             no_gaps      = 1'b0;

    int               err_count    = 0;
    int               stall_cycles = 0;
    logic             req_taken    = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_nodes(input logic [grc_pkg::NC_W-1:0] v);
        if (v == '0) return 1;
        if (v > NODES) return NODES;
        return int'(v);
    endfunction

    function automatic logic [grc_pkg::ROW_W-1:0] in_use_mask(input int n);
        if (n >= grc_pkg::ROW_W) return '1;
        return (grc_pkg::ROW_W'(1) << n) - grc_pkg::ROW_W'(1);
    endfunction

    // Forward closure from node 0, then backward closure into the end node
    function automatic grc_pkg::t_verdict predict_verdict();
        int                        n;
        int                        i;
        logic [grc_pkg::ROW_W-1:0] mask;
        logic [grc_pkg::ROW_W-1:0] fwd;
        logic [grc_pkg::ROW_W-1:0] bwd;
        logic [grc_pkg::ROW_W-1:0] prev;
        n    = active_nodes(model_nc);
        mask = in_use_mask(n);
        fwd  = grc_pkg::ROW_W'(1);
        do begin
            prev = fwd;
            for (i = 0; i < n; i++) begin
                if (fwd[i]) fwd = fwd | (model_rows[i] & mask);
            end
        end while (fwd != prev);
        bwd = grc_pkg::ROW_W'(1) << (n - 1);
        do begin
            prev = bwd;
            for (i = 0; i < n; i++) begin
                if ((model_rows[i] & mask & bwd) != '0) bwd[i] = 1'b1;
            end
        end while (bwd != prev);
        if (fwd != mask) return grc_pkg::V_UNREACH;
        if (bwd != mask) return grc_pkg::V_NO_END;
        return grc_pkg::V_PASS;
    endfunction

    // Monitor: track accepted requests, config writes and verdict strobes
    always @(posedge i_clk) begin
        grc_pkg::t_verdict want;
        logic              progress;
        progress = 1'b0;
        if (!i_rst_n) begin
            model_nc = grc_pkg::NC_RESET;
        end else begin
            if (o_valid) begin
                progress = 1'b1;
                if (expected_verdicts.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected verdict %0d with none pending", o_verdict);
                end else begin
                    want = expected_verdicts[0];
                    expected_verdicts.delete(0);
                    if (o_verdict !== want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("verdict mismatch: expected %0d (%s), got %0d",
                                     want, want.name(), o_verdict);
                    end
                end
            end
            if (start && !busy) begin
                progress = 1'b1;
                model_rows[i_row_index] = i_row_bits;
                if (i_last_row)
                    expected_verdicts.insert(expected_verdicts.size(), predict_verdict());
            end
            if (i_cfg_valid && o_cfg_ready) begin
                progress = 1'b1;
                model_nc = i_cfg_data;
            end
        end
        req_taken    <= i_rst_n && start && !busy;
        stall_cycles <= progress ? 0 : stall_cycles + 1;
    end

    // Driver: present the next request once the current one is taken
    always @(negedge i_clk) begin
        t_row_req nxt;
        if (i_rst_n && (!start || req_taken)) begin
            if (pending_rows.size() != 0 && (no_gaps || $urandom_range(99) >= 6)) begin
                nxt = pending_rows[0];
                pending_rows.delete(0);
                start       <= 1'b1;
                i_row_index <= nxt.idx;
                i_row_bits  <= nxt.bits;
                i_last_row  <= nxt.last;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_row(input int idx, input logic [grc_pkg::ROW_W-1:0] bits,
                            input logic last);
        t_row_req r;
        r.idx  = grc_pkg::IDX_W'(idx);
        r.bits = bits;
        r.last = last;
        pending_rows.insert(pending_rows.size(), r);
        rows_loaded[idx] = 1'b1;
        gen_count++;
    endtask

    // Hold until every request is taken and every verdict is back
    task automatic wait_idle();
        while (pending_rows.size() != 0 || start || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [grc_pkg::NC_W-1:0] v);
        wait_idle();
        repeat ($urandom_range(2)) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= grc_pkg::NC_W'($urandom);
        gen_nodes = active_nodes(v);
    endtask

    // Build one graph for the current node count and queue its rows in random order
    task automatic queue_graph(input t_graph_kind kind);
        int                        n;
        int                        j;
        int                        k;
        int                        pick;
        logic [grc_pkg::ROW_W-1:0] mask;
        logic [grc_pkg::ROW_W-1:0] rows [NODES];
        t_row_req                  burst[$];
        t_row_req                  r;
        n    = gen_nodes;
        mask = in_use_mask(n);
        for (j = 0; j < n; j++) begin
            if (kind == G_RANDOM && $urandom_range(1) == 1)
                rows[j] = $urandom;
            else
                rows[j] = $urandom & $urandom & $urandom;
            // chain every node to the next so the base graph passes
            if (kind != G_RANDOM && j < n - 1) rows[j][j+1] = 1'b1;
        end
        case (kind)
            G_CUT: begin
                // drop every edge into one node
                if (n > 1) begin
                    k = $urandom_range(n - 1, 1);
                    for (j = 0; j < n; j++) rows[j][k] = 1'b0;
                end
            end
            G_DEAD_END: begin
                // reach everything from the start, strand one inner node
                if (n > 2) begin
                    k = $urandom_range(n - 2, 1);
                    rows[0] = rows[0] | mask;
                    rows[k] = '0;
                end
            end
            default: ;
        endcase
        for (j = 0; j < n; j++) begin
            if ($urandom_range(1) == 1) rows[j] = rows[j] | ($urandom & ~mask);
        end
        // rows already stored may be left as they are
        for (j = 0; j < n; j++) begin
            if (!rows_loaded[j] || $urandom_range(99) < 85) begin
                r.idx  = grc_pkg::IDX_W'(j);
                r.bits = rows[j];
                r.last = 1'b0;
                burst.insert(burst.size(), r);
            end
        end
        // rows out of use are stored but ignored
        if (n < NODES) begin
            repeat ($urandom_range(2)) begin
                r.idx  = grc_pkg::IDX_W'($urandom_range(NODES - 1, n));
                r.bits = $urandom;
                r.last = 1'b0;
                burst.insert(burst.size(), r);
            end
        end
        if (burst.size() == 0) begin
            r.idx  = '0;
            r.bits = rows[0];
            r.last = 1'b0;
            burst.insert(burst.size(), r);
        end
        for (j = burst.size() - 1; j > 0; j--) begin
            k        = $urandom_range(j);
            r        = burst[j];
            burst[j] = burst[k];
            burst[k] = r;
        end
        pick = $urandom_range(burst.size() - 1);
        r    = burst[pick];
        burst.delete(pick);
        r.last = 1'b1;
        burst.insert(burst.size(), r);
        for (j = 0; j < burst.size(); j++)
            push_row(burst[j].idx, burst[j].bits, burst[j].last);
    endtask

    // Stimulus: reset, directed graphs, then random phases of node counts
    initial begin
        logic [grc_pkg::NC_W-1:0] nc;
        logic [grc_pkg::NC_W-1:0] first_counts [5];
        int                       phase;
        int                       sel;
        int                       random_base;
        first_counts = '{grc_pkg::NC_W'(32), grc_pkg::NC_W'(1), grc_pkg::NC_W'(63),
                         grc_pkg::NC_W'(0), grc_pkg::NC_W'(2)};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single node: start is also the end
        write_node_count(grc_pkg::NC_W'(1));
        push_row(0, '0, 1'b1);
        // zero count acts as one node, out-of-use bits ignored
        write_node_count(grc_pkg::NC_W'(0));
        push_row(0, '1, 1'b1);
        // two nodes: pass, then start with no edges, then back edge only
        write_node_count(grc_pkg::NC_W'(2));
        push_row(1, '0, 1'b0);
        push_row(0, 32'h0000_0002, 1'b1);
        push_row(0, '0, 1'b1);
        push_row(1, 32'h0000_0001, 1'b0);
        push_row(0, 32'hFFFF_FFFC, 1'b1);
        // three nodes: inner node cannot reach the end, then repaired
        write_node_count(grc_pkg::NC_W'(3));
        push_row(2, '0, 1'b0);
        push_row(31, '1, 1'b0);
        push_row(0, 32'h0000_0006, 1'b0);
        push_row(1, '0, 1'b1);
        push_row(1, 32'h0000_0004, 1'b1);
        push_row(2, 32'hFFFF_FFF8, 1'b1);
        // last flag on a row out of use still runs the check
        push_row(20, '1, 1'b1);

        random_base = gen_count;
        phase       = 0;
        while (gen_count < random_base + RANDOM_ITEMS) begin
            if (phase < 5) begin
                nc = first_counts[phase];
            end else begin
                sel = $urandom_range(99);
                if (sel < 65)      nc = grc_pkg::NC_W'($urandom_range(8, 2));
                else if (sel < 85) nc = grc_pkg::NC_W'($urandom_range(31, 9));
                else if (sel < 93) nc = grc_pkg::NC_W'(32);
                else if (sel < 96) nc = grc_pkg::NC_W'($urandom_range(63, 33));
                else               nc = grc_pkg::NC_W'($urandom_range(1, 0));
            end
            write_node_count(nc);
            no_gaps = (gen_count - random_base >= 400) && (gen_count - random_base < 650);
            repeat ($urandom_range(6, 2)) queue_graph(t_graph_kind'($urandom_range(3)));
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
src/grc_pkg.sv
src/grc_row_mem.sv
src/grc_closure.sv
src/graph_reachability_check.sv
dv/tb_graph_reachability_check.sv
